/* hw/rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int KEY_BITS   = 32;
    localparam int ID_BITS    = 16;
    localparam int HEAP_DEPTH = 64;
    localparam int FILL_BITS  = 7;
    localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_POPPED    = 2'd1,
        ST_POP_EMPTY = 2'd2,
        ST_INS_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 opcode;
        logic [KEY_BITS-1:0] item_key;
        logic [ID_BITS-1:0]  item_id;
    } req_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  popped_key;
        logic [ID_BITS-1:0]   popped_id;
        status_t              status;
        logic [FILL_BITS-1:0] fill_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic up_read;
        logic up_move;
        logic wr_moving;
        logic pop_root;
        logic pop_last;
        logic dn_read_left;
        logic dn_read_right;
        logic dn_move;
        logic load_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
        logic hole_zero;
        logic cnt_zero;
        logic left_ok;
        logic up_swap;
        logic dn_swap;
    } stat_t;

endpackage

/* hw/rtl/bmhq_ram.sv */
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bmhq_ctrl.sv */
`timescale 1ns / 1ps

module bmhq_ctrl import bmhq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_UP_RD    = 9'b000000010,
        S_UP_CMP   = 9'b000000100,
        S_POP_ROOT = 9'b000001000,
        S_POP_LAST = 9'b000010000,
        S_DN_RDL   = 9'b000100000,
        S_DN_RDR   = 9'b001000000,
        S_DN_CMP   = 9'b010000000,
        S_FIN      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (stat.req_pop)
                    begin
                        state_next = stat.empty ? S_FIN : S_POP_ROOT;
                    end
                    else
                    begin
                        state_next = stat.full ? S_FIN : S_UP_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                if (stat.hole_zero)
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_swap)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_POP_ROOT:
            begin
                cmd.pop_root = 1'b1;
                state_next   = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                cmd.pop_last = 1'b1;
                state_next   = stat.cnt_zero ? S_FIN : S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (stat.left_ok)
                begin
                    cmd.dn_read_left = 1'b1;
                    state_next       = S_DN_RDR;
                end
                else
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_DN_RDR:
            begin
                cmd.dn_read_right = 1'b1;
                state_next        = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (stat.dn_swap)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RDL;
                end
                else
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/bmhq_dp.sv */
`timescale 1ns / 1ps

module bmhq_dp import bmhq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    output rsp_t  rsp,
    input  cmd_t  cmd,
    output stat_t stat
);

    localparam int AW = ADDR_BITS;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [AW-1:0]       hole_reg;
    logic [AW-1:0]       hole_next;
    entry_t              moving_reg;
    entry_t              moving_next;
    entry_t              child_reg;
    logic [AW-1:0]       child_idx_reg;
    logic [KEY_BITS-1:0] res_key_reg;
    logic [ID_BITS-1:0]  res_id_reg;
    status_t             res_status_reg;
    rsp_t                out_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    entry_t              ram_rdata;

    logic [AW-1:0]       hole_m1;
    logic [AW-1:0]       parent_idx;
    logic [AW+1:0]       left_w;
    logic [AW+1:0]       right_w;
    logic [AW+1:0]       count_w;
    logic                right_ok;
    logic                sel_right;
    entry_t              cand;
    logic [AW-1:0]       cand_idx;

    bmhq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(HEAP_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // slot index arithmetic
    assign hole_m1    = hole_reg - 1'b1;
    assign parent_idx = hole_m1 >> 1;
    assign left_w     = {1'b0, hole_reg, 1'b1};
    assign right_w    = left_w + 1'b1;
    assign count_w    = (AW + 2)'(count_reg);
    assign right_ok   = (right_w < count_w);

    // smaller child, left one on a tie
    assign sel_right = right_ok && (ram_rdata.key < child_reg.key);
    assign cand      = sel_right ? ram_rdata : child_reg;
    assign cand_idx  = sel_right ? right_w[AW-1:0] : child_idx_reg;

    assign stat.req_pop   = (req.opcode == OP_POP);
    assign stat.full      = (count_reg == CNT_BITS'(HEAP_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.hole_zero = (hole_reg == '0);
    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.left_ok   = (left_w < count_w);
    assign stat.up_swap   = (moving_reg.key < ram_rdata.key);
    assign stat.dn_swap   = (cand.key < moving_reg.key);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = hole_reg;
        ram_wdata = moving_reg;
        if (cmd.up_move)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (cmd.dn_move)
        begin
            ram_we    = 1'b1;
            ram_wdata = cand;
        end
        else if (cmd.wr_moving)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.start && stat.req_pop)
        begin
            ram_re = 1'b1;
        end
        else if (cmd.up_read)
        begin
            ram_re    = 1'b1;
            ram_raddr = parent_idx;
        end
        else if (cmd.pop_root)
        begin
            // count already holds the index of the last entry
            ram_re    = 1'b1;
            ram_raddr = count_reg[AW-1:0];
        end
        else if (cmd.dn_read_left)
        begin
            ram_re    = 1'b1;
            ram_raddr = left_w[AW-1:0];
        end
        else if (cmd.dn_read_right)
        begin
            ram_re    = 1'b1;
            ram_raddr = right_w[AW-1:0];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        hole_next   = hole_reg;
        moving_next = moving_reg;
        if (cmd.start)
        begin
            if (stat.req_pop && !stat.empty)
            begin
                count_next = count_reg - 1'b1;
            end
            else if (!stat.req_pop && !stat.full)
            begin
                count_next     = count_reg + 1'b1;
                hole_next      = count_reg[AW-1:0];
                moving_next.key = req.item_key;
                moving_next.id  = req.item_id;
            end
        end
        else if (cmd.up_move)
        begin
            hole_next = parent_idx;
        end
        else if (cmd.pop_last)
        begin
            hole_next   = '0;
            moving_next = ram_rdata;
        end
        else if (cmd.dn_move)
        begin
            hole_next = cand_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg   <= hole_next;
        moving_reg <= moving_next;
        if (cmd.dn_read_right)
        begin
            child_reg     <= ram_rdata;
            child_idx_reg <= left_w[AW-1:0];
        end
        if (cmd.start)
        begin
            res_key_reg <= '0;
            res_id_reg  <= '0;
            if (stat.req_pop)
            begin
                res_status_reg <= stat.empty ? ST_POP_EMPTY : ST_POPPED;
            end
            else
            begin
                res_status_reg <= stat.full ? ST_INS_FULL : ST_INSERTED;
            end
        end
        else if (cmd.pop_root)
        begin
            res_key_reg <= ram_rdata.key;
            res_id_reg  <= ram_rdata.id;
        end
        if (cmd.load_out)
        begin
            out_reg.popped_key <= res_key_reg;
            out_reg.popped_id  <= res_id_reg;
            out_reg.status     <= res_status_reg;
            out_reg.fill_count <= FILL_BITS'(count_reg);
        end
    end

    assign rsp = out_reg;

    // the sift sequence never reads and writes the store in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and written in the same cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && !stat.req_pop && !stat.full |=>
            count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the heap by one");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && stat.req_pop && !stat.empty |=>
            count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink the heap by one");

endmodule

/* hw/rtl/binary_min_heap_queue.sv */
`timescale 1ns / 1ps

// Min-heap priority queue of (key, id) pairs held in one single-port-read RAM of
// HEAP_DEPTH entries. Each request either inserts a pair or pops the smallest key;
// every request gives exactly one response with a status and the fill count after
// the operation. Requests are taken one at a time. An insert climbs one level per
// step (read parent, compare and move) until a compare stops it or it reaches the
// root; a pop reads the root and then the last entry, then sinks one level per step
// (read left child, read right child, compare and move) until a compare stops it
// or the hole has no left child. A pop on empty or an insert on full goes straight
// to the response. The one RAM read port serialises these reads. The response
// sits in an output register, so the next request is taken while it waits to be
// transferred; a request finishing while that register still waits holds until
// it is free.

module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmhq_dp u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cmd  (cmd),
        .stat (stat)
    );

endmodule
